[hw/rtl/kec_pkg.sv]
// kec_pkg: shared types and constants of the key event classifier
// event codes, register indexes, per-key state record and its reset value
// used by key_event_classifier_unit
package kec_pkg;

   localparam int DEFAULT_NUM_KEYS = 16;

   localparam logic [2:0] EV_NOTHING      = 3'd0;
   localparam logic [2:0] EV_PRESS        = 3'd1;
   localparam logic [2:0] EV_CLICK        = 3'd2;
   localparam logic [2:0] EV_LONGCLICK    = 3'd3;
   localparam logic [2:0] EV_PRESSING     = 3'd4;
   localparam logic [2:0] EV_LONGPRESSING = 3'd5;
   localparam logic [2:0] EV_RELEASE      = 3'd6;

   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_DEFINE = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_CLICK_TIME     = 2'd0;
   localparam logic [1:0] CSR_LONGCLICK_TIME = 2'd1;
   localparam logic [1:0] CSR_REPEAT_PERIOD  = 2'd2;

   typedef struct packed {
      logic        pressed_now;
      logic        pressed_before;
      logic        ignore;
      logic [2:0]  last_event;
      logic [31:0] change_time;
      logic [31:0] repeat_time;
   } key_state_type;

   localparam key_state_type KEY_STATE_RESET = '{
      pressed_now:    1'b0,
      pressed_before: 1'b0,
      ignore:         1'b1,
      last_event:     EV_NOTHING,
      change_time:    32'd0,
      repeat_time:    32'd0
   };

endpackage

[hw/rtl/key_event_classifier_unit.sv]
// key_event_classifier_unit: top level of the key event classifier
// depends on kec_pkg and kec_ram
// slot table and per-key state live in two kec_ram instances
//
// A request in sample mode walks the key table one slot per cycle from slot 0
// until the first empty slot, the last slot, or a slot whose key was pressed
// before or whose last event is neither nothing nor a release; a slot that
// matches the scan pattern selects its key too, but the walk goes on. The
// selected key then gets time checks in S_CHK_CLICK, S_CHK_LONG and S_CHK_REP
// on one shared 32-bit adder; S_SAMPLE classifies and writes back its state
// and S_OUT loads the response register. Clear requests walk to the first
// empty or the last slot; define and unused requests go straight to S_OUT.
// Every request gives exactly one response transfer. req_stall is high from
// the request transfer until its response is loaded, and the response is
// loaded only once the previous response has been transferred. Slot patterns,
// codes and key states read as their reset values until written, through
// per-slot valid flags, so no clearing pass is needed after reset.
module key_event_classifier_unit
   import kec_pkg::*;
#(
   parameter int NUM_KEYS = DEFAULT_NUM_KEYS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_ticks,
   input  logic [31:0] req_scan_pattern,
   input  logic [3:0]  req_slot_index,
   input  logic [7:0]  req_slot_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_event_key_code,
   output logic [2:0]  rsp_event_kind,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int SW = $bits(key_state_type);
   localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EVAL      = 3'd1;
   localparam logic [2:0] S_CHK_CLICK = 3'd2;
   localparam logic [2:0] S_CHK_LONG  = 3'd3;
   localparam logic [2:0] S_CHK_REP   = 3'd4;
   localparam logic [2:0] S_SAMPLE    = 3'd5;
   localparam logic [2:0] S_OUT       = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic [1:0]    mode_ff, mode_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   pat_ff, pat_in;
   logic          found_ff, found_in;
   logic [KW-1:0] sel_ff, sel_in;
   logic [7:0]    sel_code_ff, sel_code_in;
   key_state_type sel_st_ff, sel_st_in;
   logic          exp_click_ff, exp_click_in;
   logic          exp_long_ff, exp_long_in;
   logic          exp_rep_ff, exp_rep_in;
   logic [7:0]    res_code_ff, res_code_in;
   logic [2:0]    res_kind_ff, res_kind_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_code_ff, rsp_code_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [NUM_KEYS-1:0] slot_vld_ff, slot_vld_in;
   logic [NUM_KEYS-1:0] state_vld_ff, state_vld_in;
   logic [31:0]   click_ff, long_ff, period_ff;

   logic          slot_wr_en;
   logic [KW-1:0] slot_wr_addr;
   logic [39:0]   slot_wr_data;
   logic [KW-1:0] rd_addr;
   logic [39:0]   slot_rd;
   logic          st_wr_en;
   logic [KW-1:0] st_wr_addr;
   key_state_type st_wr_data;
   logic [SW-1:0] st_rd;

   logic          req_xfer;
   logic [31:0]   cur_pat;
   logic [7:0]    cur_code;
   key_state_type cur_st;
   logic          is_last;
   logic [31:0]   op_base, op_delay, op_sum;
   key_state_type nst;
   logic [2:0]    ev;

   kec_ram #(.WIDTH(40), .DEPTH(NUM_KEYS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (rd_addr),
      .rd_data (slot_rd)
   );

   kec_ram #(.WIDTH(SW), .DEPTH(NUM_KEYS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (rd_addr),
      .rd_data (st_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign cur_pat  = slot_vld_ff[k_ff] ? slot_rd[39:8] : 32'd0;
   assign cur_code = slot_vld_ff[k_ff] ? slot_rd[7:0] : 8'd0;
   assign cur_st   = state_vld_ff[k_ff] ? key_state_type'(st_rd) : KEY_STATE_RESET;
   assign is_last  = (k_ff == LAST_KEY);

   // shared time check unit: base + delay - now
   always_comb begin
      case (state_ff)
         S_CHK_LONG: begin
            op_base  = sel_st_ff.change_time;
            op_delay = long_ff;
         end
         S_CHK_REP: begin
            op_base  = sel_st_ff.repeat_time;
            op_delay = period_ff;
         end
         default: begin
            op_base  = sel_st_ff.change_time;
            op_delay = click_ff;
         end
      endcase
      op_sum = op_base + op_delay - now_ff;
   end

   // classification of the selected key
   always_comb begin
      nst = sel_st_ff;
      ev  = EV_NOTHING;
      if (sel_st_ff.pressed_now == sel_st_ff.pressed_before) begin
         if (!sel_st_ff.ignore) begin
            if (sel_st_ff.last_event == EV_PRESS && sel_st_ff.pressed_now && exp_click_ff) begin
               ev                = EV_CLICK;
               nst.repeat_time   = now_ff;
               nst.last_event    = EV_CLICK;
            end else if (sel_st_ff.last_event != EV_RELEASE && !sel_st_ff.pressed_now &&
                         exp_click_ff) begin
               ev                = EV_RELEASE;
               nst.last_event    = EV_RELEASE;
            end else if ((sel_st_ff.last_event == EV_CLICK ||
                          sel_st_ff.last_event == EV_PRESS) && exp_long_ff) begin
               ev                = EV_LONGCLICK;
               nst.change_time   = now_ff;
               nst.repeat_time   = now_ff;
               nst.last_event    = EV_LONGCLICK;
            end else if (sel_st_ff.last_event == EV_LONGCLICK && sel_st_ff.pressed_now &&
                         exp_rep_ff) begin
               ev                = EV_LONGPRESSING;
               nst.repeat_time   = now_ff;
            end else if (sel_st_ff.last_event == EV_CLICK && sel_st_ff.pressed_now &&
                         exp_rep_ff) begin
               ev                = EV_PRESSING;
               nst.repeat_time   = now_ff;
            end
         end
      end else begin
         nst.ignore         = 1'b0;
         nst.pressed_before = sel_st_ff.pressed_now;
         nst.change_time    = now_ff;
         if (sel_st_ff.pressed_now) begin
            ev             = EV_PRESS;
            nst.last_event = EV_PRESS;
         end else if (sel_st_ff.last_event == EV_PRESS) begin
            ev             = EV_RELEASE;
            nst.last_event = EV_RELEASE;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      pat_in       = pat_ff;
      found_in     = found_ff;
      sel_in       = sel_ff;
      sel_code_in  = sel_code_ff;
      sel_st_in    = sel_st_ff;
      exp_click_in = exp_click_ff;
      exp_long_in  = exp_long_ff;
      exp_rep_in   = exp_rep_ff;
      res_code_in  = res_code_ff;
      res_kind_in  = res_kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_code_in  = rsp_code_ff;
      rsp_kind_in  = rsp_kind_ff;
      slot_vld_in  = slot_vld_ff;
      state_vld_in = state_vld_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = KW'(req_slot_index);
      slot_wr_data = {req_scan_pattern, req_slot_code};
      rd_addr      = k_ff;
      st_wr_en     = 1'b0;
      st_wr_addr   = k_ff;
      st_wr_data   = cur_st;

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (req_xfer) begin
               mode_in     = req_mode;
               now_in      = req_now_ticks;
               pat_in      = req_scan_pattern;
               k_in        = '0;
               found_in    = 1'b0;
               res_code_in = 8'd0;
               res_kind_in = EV_NOTHING;
               if (req_mode == MODE_SAMPLE || req_mode == MODE_CLEAR) begin
                  state_in = S_EVAL;
               end else begin
                  state_in = S_OUT;
                  if (req_mode == MODE_DEFINE && 32'(req_slot_index) < NUM_KEYS) begin
                     slot_wr_en                 = 1'b1;
                     slot_vld_in[slot_wr_addr]  = 1'b1;
                  end
               end
            end
         end
         S_EVAL: begin
            rd_addr = k_ff + KW'(1);
            if (cur_pat == 32'd0) begin
               state_in = (mode_ff == MODE_SAMPLE && found_ff) ? S_CHK_CLICK : S_OUT;
            end else if (mode_ff == MODE_CLEAR) begin
               state_vld_in[k_ff] = 1'b0;
               k_in               = k_ff + KW'(1);
               if (is_last) begin
                  state_in = S_OUT;
               end
            end else if (cur_pat == pat_ff) begin
               st_wr_en               = 1'b1;
               st_wr_data.pressed_now = 1'b1;
               state_vld_in[k_ff]     = 1'b1;
               found_in               = 1'b1;
               sel_in                 = k_ff;
               sel_code_in            = cur_code;
               sel_st_in              = cur_st;
               sel_st_in.pressed_now  = 1'b1;
               k_in                   = k_ff + KW'(1);
               if (is_last) begin
                  state_in = S_CHK_CLICK;
               end
            end else if (cur_st.pressed_before) begin
               found_in              = 1'b1;
               sel_in                = k_ff;
               sel_code_in           = cur_code;
               sel_st_in             = cur_st;
               sel_st_in.pressed_now = 1'b0;
               state_in              = S_CHK_CLICK;
            end else if (cur_st.last_event != EV_RELEASE &&
                         cur_st.last_event != EV_NOTHING) begin
               found_in    = 1'b1;
               sel_in      = k_ff;
               sel_code_in = cur_code;
               sel_st_in   = cur_st;
               state_in    = S_CHK_CLICK;
            end else begin
               k_in = k_ff + KW'(1);
               if (is_last) begin
                  state_in = found_ff ? S_CHK_CLICK : S_OUT;
               end
            end
         end
         S_CHK_CLICK: begin
            exp_click_in = op_sum[31];
            state_in     = S_CHK_LONG;
         end
         S_CHK_LONG: begin
            exp_long_in = op_sum[31];
            state_in    = S_CHK_REP;
         end
         S_CHK_REP: begin
            exp_rep_in = op_sum[31];
            state_in   = S_SAMPLE;
         end
         S_SAMPLE: begin
            st_wr_en             = 1'b1;
            st_wr_addr           = sel_ff;
            st_wr_data           = nst;
            state_vld_in[sel_ff] = 1'b1;
            res_code_in          = sel_code_ff;
            res_kind_in          = ev;
            state_in             = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
               rsp_kind_in  = res_kind_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_vld_ff  <= '0;
         state_vld_ff <= '0;
         found_ff     <= 1'b0;
         click_ff     <= 32'd0;
         long_ff      <= 32'd0;
         period_ff    <= 32'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_vld_ff  <= slot_vld_in;
         state_vld_ff <= state_vld_in;
         found_ff     <= found_in;
         if (csr_write) begin
            case (csr_index)
               CSR_CLICK_TIME:     click_ff  <= csr_wdata;
               CSR_LONGCLICK_TIME: long_ff   <= csr_wdata;
               CSR_REPEAT_PERIOD:  period_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      mode_ff      <= mode_in;
      now_ff       <= now_in;
      pat_ff       <= pat_in;
      sel_ff       <= sel_in;
      sel_code_ff  <= sel_code_in;
      sel_st_ff    <= sel_st_in;
      exp_click_ff <= exp_click_in;
      exp_long_ff  <= exp_long_in;
      exp_rep_ff   <= exp_rep_in;
      res_code_ff  <= res_code_in;
      res_kind_ff  <= res_kind_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_key_code = rsp_code_ff;
   assign rsp_event_kind     = rsp_kind_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while a request is in progress");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && rsp_stall)) |-> $past(state_ff == S_OUT))
      else $error("response loaded outside the output step");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind <= EV_RELEASE))
      else $error("event kind out of range");

   a_write_back_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SAMPLE) |=> state_vld_ff[sel_ff])
      else $error("written key state not marked valid");
`endif

endmodule

[hw/rtl/kec_ram.sv]
// kec_ram: generic single write port, single read port RAM
// read data is registered; no reset on the array
// no package dependency
module kec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
